/* rtl/dfscd_pkg.sv */
// Package for the depth-first cycle detector: beat types, color and
// sequencer state encodings, status and kind codes.
// No dependencies.
package dfscd_pkg;

  localparam int unsigned VtxW    = 7;
  localparam int unsigned TimeW   = 8;
  localparam int unsigned StatusW = 2;

  localparam logic [VtxW-1:0] VCountReset = 7'd64;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  localparam logic [StatusW-1:0] STATUS_NONE    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_CYCLE   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NO_ROOT = 2'd2;

  typedef struct packed {
    logic            kind;
    logic [VtxW-1:0] edge_source;
    logic [VtxW-1:0] edge_target;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TimeW-1:0]   final_time;
  } out_item_t;

  typedef logic [VtxW-1:0] cfg_item_t;

  typedef enum logic [1:0] {
    COL_WHITE = 2'd0,
    COL_GREY  = 2'd1,
    COL_BLACK = 2'd2
  } color_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT,
    ST_SCAN,
    ST_POP,
    ST_DONE
  } state_e;

endpackage

/* rtl/dfscd_stream_if.sv */
// Valid/ready channel carrying one beat of type T.
// Used with the types of dfscd_pkg.
interface dfscd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/dfscd_search.sv */
// Edge loader and depth-first search sequencer: adjacency row memory,
// stack memory, color and incoming-mark stores, one-step neighbor scan.
// Depends on dfscd_pkg.
module dfscd_search #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]         n_i,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  dfscd_pkg::in_item_t                       in_data_i,
  output logic                                      res_valid_o,
  input  logic                                      res_ready_i,
  output dfscd_pkg::out_item_t                      res_data_o
);
  import dfscd_pkg::*;

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned XW = (CW > VtxW) ? CW : VtxW;
  localparam int unsigned SW = VW + CW;
  localparam logic [VW-1:0] LastRow = VW'(MAX_VERTICES - 1);

  state_e state_q, state_d;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_q;
  logic [SW-1:0]           stk_mem [MAX_VERTICES];
  logic [SW-1:0]           stk_rd_q;

  logic                    inc_mem [MAX_VERTICES];
  logic                    inc_rd_q;
  color_e                  col_mem [MAX_VERTICES];
  color_e                  col_rd_q;
  logic [VW-1:0]           rd_addr;
  logic [VW-1:0]           clr_q, clr_d;

  logic [CW-1:0]      root_q, root_d;
  logic               found_q, found_d;
  logic [VW-1:0]      v_q, v_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      depth_q, depth_d;
  logic [TimeW-1:0]   time_q, time_d;
  logic [StatusW-1:0] status_q, status_d;

  logic          set_we;
  logic [VW-1:0] set_row, set_col;
  logic          clr_we;
  logic          adj_re;
  logic [VW-1:0] adj_raddr;
  logic          stk_we, stk_re;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata;
  logic          col_we;
  logic [VW-1:0] col_idx;
  color_e        col_val;

  logic          edge_ok;
  logic          w_end;
  logic [VW-1:0] root_idx, w_idx;
  logic          run_beat;

  assign root_idx = VW'(root_q);
  assign w_idx    = VW'(pos_q);
  assign w_end    = (pos_q >= n_i);
  assign run_beat = in_valid_i && (in_data_i.kind == KIND_RUN);
  assign edge_ok  = (in_data_i.edge_source != '0) && (in_data_i.edge_target != '0)
                 && (XW'(in_data_i.edge_source) <= XW'(n_i))
                 && (XW'(in_data_i.edge_target) <= XW'(n_i));
  assign rd_addr  = (state_d == ST_ROOT) ? VW'(root_d) : VW'(pos_d);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastRow) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (run_beat) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_q == n_i) begin
          state_d = ST_DONE;
        end else if (!inc_rd_q && col_rd_q == COL_WHITE) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (w_end) begin
          state_d = (depth_q == CW'(1)) ? ST_ROOT : ST_POP;
        end else if (row_q[w_idx] && col_rd_q == COL_GREY) begin
          state_d = ST_DONE;
        end
      end
      ST_POP: state_d = ST_SCAN;
      ST_DONE: begin
        if (res_ready_i) state_d = ST_CLEAR;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    clr_d    = clr_q;
    root_d   = root_q;
    found_d  = found_q;
    v_d      = v_q;
    pos_d    = pos_q;
    depth_d  = depth_q;
    time_d   = time_q;
    status_d = status_q;
    set_we    = 1'b0;
    set_row   = VW'(in_data_i.edge_source - 7'd1);
    set_col   = VW'(in_data_i.edge_target - 7'd1);
    clr_we    = 1'b0;
    adj_re    = 1'b0;
    adj_raddr = root_idx;
    stk_we    = 1'b0;
    stk_waddr = VW'(depth_q - CW'(1));
    stk_wdata = {v_q, CW'(pos_q + 1'b1)};
    stk_re    = 1'b0;
    stk_raddr = VW'(depth_q - CW'(2));
    col_we      = 1'b0;
    col_idx     = root_idx;
    col_val     = COL_GREY;
    unique case (state_q)
      ST_CLEAR: begin
        clr_we  = 1'b1;
        clr_d   = clr_q + 1'b1;
        col_we  = 1'b1;
        col_idx = clr_q;
        col_val = COL_WHITE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        clr_d      = '0;
        if (in_valid_i && in_data_i.kind == KIND_EDGE && edge_ok) begin
          set_we = 1'b1;
        end
        if (run_beat) begin
          root_d      = '0;
          found_d     = 1'b0;
          time_d      = '0;
          status_d    = STATUS_NONE;
        end
      end
      ST_ROOT: begin
        if (root_q == n_i) begin
          if (!found_q) begin
            status_d = STATUS_NO_ROOT;
            time_d   = '0;
          end
        end else if (inc_rd_q) begin
          root_d = root_q + 1'b1;
        end else begin
          found_d = 1'b1;
          if (col_rd_q != COL_WHITE) begin
            root_d = root_q + 1'b1;
          end else begin
            col_we    = 1'b1;
            time_d    = time_q + 1'b1;
            v_d       = root_idx;
            pos_d     = '0;
            depth_d   = CW'(1);
            adj_re    = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (w_end) begin
          col_we  = 1'b1;
          col_idx = v_q;
          col_val = COL_BLACK;
          time_d  = time_q + 1'b1;
          depth_d = depth_q - 1'b1;
          if (depth_q == CW'(1)) begin
            root_d = root_q + 1'b1;
          end else begin
            stk_re = 1'b1;
          end
        end else begin
          pos_d = pos_q + 1'b1;
          if (row_q[w_idx]) begin
            case (col_rd_q)
              COL_GREY: status_d = STATUS_CYCLE;
              COL_WHITE: begin
                stk_we    = 1'b1;
                col_we    = 1'b1;
                col_idx   = w_idx;
                time_d    = time_q + 1'b1;
                depth_d   = depth_q + 1'b1;
                v_d       = w_idx;
                pos_d     = '0;
                adj_re    = 1'b1;
                adj_raddr = w_idx;
              end
              default: ;
            endcase
          end
        end
      end
      ST_POP: begin
        v_d       = stk_rd_q[SW-1:CW];
        pos_d     = stk_rd_q[CW-1:0];
        adj_re    = 1'b1;
        adj_raddr = stk_rd_q[SW-1:CW];
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        clr_d       = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q   <= root_d;
    found_q  <= found_d;
    v_q      <= v_d;
    pos_q    <= pos_d;
    depth_q  <= depth_d;
    time_q   <= time_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      inc_mem[clr_q] <= 1'b0;
    end else if (set_we) begin
      inc_mem[set_col] <= 1'b1;
    end
    inc_rd_q <= inc_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[col_idx] <= col_val;
    end
    if (col_we && col_idx == rd_addr) begin
      col_rd_q <= col_val;
    end else begin
      col_rd_q <= col_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      adj_mem[clr_q] <= '0;
    end else if (set_we) begin
      adj_mem[set_row][set_col] <= 1'b1;
    end
    if (adj_re) begin
      row_q <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  assign res_data_o.status     = status_q;
  assign res_data_o.final_time = time_q;

endmodule

/* rtl/dfs_cycle_detector.sv */
// Top level of the depth-first cycle detector: configuration register,
// vertex count clamp, output register, channel wiring.
// Depends on dfscd_pkg, dfscd_stream_if and dfscd_search.

// An edge beat is taken while idle and yields no result. A run beat holds
// ready low until the result is handed to the output register and the
// adjacency store has been swept clear: the search tries each root
// candidate in turn, scans the neighbor row of each visited vertex,
// returns to the parent vertex or the next root when a row is done,
// hands over the result, then clears every row. The scan steps one
// adjacency bit per cycle out of a registered row read. After reset the
// same clearing sweep runs before the first beat is accepted; the
// configuration port is always ready.
module dfs_cycle_detector #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  dfscd_stream_if.sink                               cfg_i,
  dfscd_stream_if.sink                               in_i,
  dfscd_stream_if.source                             out_o
);
  import dfscd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  logic [VtxW-1:0] vcount_q;
  logic [CW-1:0]   n;
  logic            res_valid, res_ready;
  out_item_t       res_data;
  logic            out_valid_q;
  out_item_t       out_data_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCountReset;
    end else if (cfg_i.valid) begin
      vcount_q <= cfg_i.data;
    end
  end

  always_comb begin
    if (32'(vcount_q) > 32'(MAX_VERTICES)) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = CW'(vcount_q);
    end
  end

  dfscd_search #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

/* rtl/dfscd_checker.sv */
// Port-level checks for dfs_cycle_detector, attached by bind.
// Depends on dfscd_pkg.
module dfscd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input dfscd_pkg::in_item_t  in_data_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input dfscd_pkg::out_item_t out_data_i
);
  import dfscd_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && in_data_i.kind == KIND_RUN) |=> !in_ready_i)
    else $error("input still ready after a run beat");

  a_edge_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && in_data_i.kind == KIND_EDGE) |=> in_ready_i)
    else $error("ready dropped after an edge beat");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.status == STATUS_NONE || out_data_i.status == STATUS_CYCLE
                     || out_data_i.status == STATUS_NO_ROOT))
    else $error("undefined status code");

  a_no_root_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.status == STATUS_NO_ROOT) |-> out_data_i.final_time == '0)
    else $error("no-root result with nonzero time");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result beat changed");

endmodule

bind dfs_cycle_detector dfscd_checker u_dfscd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_data_i   (in_i.data),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

/* tb/testbench.sv */
// Testbench for dfs_cycle_detector: drives edge and search beats over listed
// and random graphs; checks each result against its own depth-first predictor
// or a given value. Depends on dfscd_pkg, dfscd_stream_if and the detector RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dfscd_pkg::*;

  localparam int MaxVtx       = 64;
  localparam int SettleCycles = MaxVtx * MaxVtx + 4 * MaxVtx + 16;
  localparam int StallLimit   = 8 * SettleCycles;
  localparam int NumPhases    = 12;

  typedef enum logic [1:0] {DO_CFG, DO_EDGE, DO_RUN} step_e;

  typedef struct {
    step_e op;
    int    src;
    int    dst;
    bit    fixed;
    int    status;
    int    ftime;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  dfscd_stream_if #(.T(cfg_item_t)) cfg_if ();
  dfscd_stream_if #(.T(in_item_t))  in_if ();
  dfscd_stream_if #(.T(out_item_t)) out_if ();

  dfs_cycle_detector #(
    .MAX_VERTICES(MaxVtx)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predictor state
  logic [MaxVtx-1:0] adj_rows [MaxVtx];
  logic              incoming [MaxVtx];
  logic [VtxW-1:0]   vcount_q;

  out_item_t expected_results [$];
  int        mismatches;
  int        src_idle_pct;
  int        sink_idle_pct;
  int        items_sent;
  int        edges_sent;
  int        cfg_writes;
  int        status_seen [4];
  int        stall_cycles;

  dir_row_t  dir_rows [29];

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic int clamped_count();
    int vc;
    vc = vcount_q;
    return (vc > MaxVtx) ? MaxVtx : vc;
  endfunction

  function automatic void clear_graph();
    for (int k = 0; k < MaxVtx; k++) begin
      adj_rows[k] = '0;
      incoming[k] = 1'b0;
    end
  endfunction

  function automatic void load_edge(input int s, input int t);
    int n;
    n = clamped_count();
    if (s >= 1 && s <= n && t >= 1 && t <= n) begin
      adj_rows[s-1][t-1] = 1'b1;
      incoming[t-1]      = 1'b1;
    end
  endfunction

  function automatic out_item_t search_graph();
    out_item_t res;
    color_e    colors  [MaxVtx];
    int        stk_vtx [MaxVtx];
    int        stk_pos [MaxVtx];
    int        n, depth, ticks, r, v, w;
    bit        any_root, cycle;
    n        = clamped_count();
    depth    = 0;
    ticks    = 0;
    any_root = 1'b0;
    cycle    = 1'b0;
    for (int k = 0; k < MaxVtx; k++) colors[k] = COL_WHITE;
    r = 0;
    while (r < n && !cycle) begin
      if (!incoming[r]) begin
        any_root = 1'b1;
        if (colors[r] == COL_WHITE) begin
          colors[r]  = COL_GREY;
          ticks++;
          stk_vtx[0] = r;
          stk_pos[0] = 0;
          depth      = 1;
          while (depth > 0 && !cycle) begin
            v = stk_vtx[depth-1];
            w = stk_pos[depth-1];
            while (w < n && !adj_rows[v][w]) w++;
            if (w >= n) begin
              colors[v] = COL_BLACK;
              ticks++;
              depth--;
            end else begin
              stk_pos[depth-1] = w + 1;
              if (colors[w] == COL_GREY) begin
                cycle = 1'b1;
              end else if (colors[w] == COL_WHITE && depth < MaxVtx) begin
                colors[w]      = COL_GREY;
                ticks++;
                stk_vtx[depth] = w;
                stk_pos[depth] = 0;
                depth++;
              end
            end
          end
        end
      end
      r++;
    end
    if (!any_root) begin
      res.status = STATUS_NO_ROOT;
      ticks      = 0;
    end else begin
      res.status = cycle ? STATUS_CYCLE : STATUS_NONE;
    end
    res.final_time = TimeW'(ticks);
    clear_graph();
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Call at a rising edge; returns at the edge that accepted the beat.
  task automatic push_item(input in_item_t it, input bit use_given = 1'b0,
                           input out_item_t given = '0);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (it.kind == KIND_EDGE) begin
      edges_sent++;
      load_edge(it.edge_source, it.edge_target);
    end else begin
      expected_results.push_back(search_graph());
      if (use_given) expected_results[$] = given;
    end
  endtask

  task automatic push_edge(input int s, input int t);
    in_item_t it;
    it.kind        = KIND_EDGE;
    it.edge_source = VtxW'(s);
    it.edge_target = VtxW'(t);
    push_item(it);
  endtask

  task automatic push_run(input bit use_given = 1'b0, input out_item_t given = '0);
    in_item_t it;
    it.kind        = KIND_RUN;
    it.edge_source = VtxW'($urandom_range(0, 127));
    it.edge_target = VtxW'($urandom_range(0, 127));
    push_item(it, use_given, given);
  endtask

  // Drop the input, drain pending results, then let the clearing sweep finish.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_vcount(input int value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= VtxW'(value);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    vcount_q      = VtxW'(value);
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic build_and_run();
    int n, shape, cnt, i, j, k, tmp;
    int perm [MaxVtx];
    n = clamped_count();
    for (k = 0; k < n; k++) perm[k] = k + 1;
    for (k = n - 1; k > 0; k--) begin
      j       = $urandom_range(0, k);
      tmp     = perm[k];
      perm[k] = perm[j];
      perm[j] = tmp;
    end
    shape = $urandom_range(0, 9);
    if (n >= 2 && shape <= 5) begin
      cnt = $urandom_range(0, n + n / 2);
      for (k = 0; k < cnt; k++) begin
        i = $urandom_range(0, n - 2);
        j = $urandom_range(i + 1, n - 1);
        push_edge(perm[i], perm[j]);
      end
      if (shape >= 4) begin
        cnt = $urandom_range(1, 2);
        for (k = 0; k < cnt; k++) begin
          j = $urandom_range(0, n - 1);
          i = $urandom_range(j, n - 1);
          push_edge(perm[i], perm[j]);
        end
      end
    end else if (n >= 2 && shape == 6) begin
      for (k = 0; k < n - 1; k++) push_edge(perm[k], perm[k+1]);
      if ($urandom_range(0, 1)) push_edge(perm[n-1], perm[$urandom_range(0, n - 1)]);
    end else if (n >= 1 && shape == 7) begin
      cnt = $urandom_range(1, n + 1);
      for (k = 0; k < cnt; k++) push_edge($urandom_range(1, n), $urandom_range(1, n));
    end else if (shape >= 6) begin
      cnt = $urandom_range(1, 6);
      for (k = 0; k < cnt; k++) push_edge($urandom_range(0, 127), $urandom_range(0, 127));
    end
    push_run();
  endtask

  // Check results and drive the output ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (status %0d, time %0d)",
                                    out_if.data.status, out_if.data.final_time));
        end else begin
          if (out_if.data.status !== expected_results[0].status)
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      out_if.data.status, expected_results[0].status));
          if (out_if.data.final_time !== expected_results[0].final_time)
            report_mismatch($sformatf("final_time got %0d, expected %0d",
                                      out_if.data.final_time,
                                      expected_results[0].final_time));
          status_seen[expected_results[0].status]++;
          void'(expected_results.pop_front());
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("no beat moved for %0d cycles", stall_cycles);
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int        phase_count [NumPhases];
    int        phase_items [NumPhases];
    int        start;
    out_item_t given;

    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    out_if.ready  = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    edges_sent    = 0;
    cfg_writes    = 0;
    stall_cycles  = 0;
    status_seen   = '{default: 0};
    vcount_q      = VCountReset;
    src_idle_pct  = 27;
    sink_idle_pct = 59;
    clear_graph();

    phase_count = '{8, 16, 64, 3, 1, 32, 127, 12, 0, 5, 24, 2};
    phase_items = '{170, 170, 170, 170, 170, 170, 170, 170, 40, 170, 170, 170};

    dir_rows = '{
      '{DO_RUN,    0,   0, 1, STATUS_NONE,    128},
      '{DO_EDGE,   2,   2, 0, 0, 0},
      '{DO_EDGE,   1,   2, 0, 0, 0},
      '{DO_RUN,  127, 127, 0, 0, 0},
      '{DO_EDGE,  64,   1, 0, 0, 0},
      '{DO_EDGE,   1,  64, 0, 0, 0},
      '{DO_RUN,    0,   0, 0, 0, 0},
      '{DO_EDGE,   0,   5, 0, 0, 0},
      '{DO_EDGE,  65,   3, 0, 0, 0},
      '{DO_EDGE, 127, 127, 0, 0, 0},
      '{DO_RUN,    0,   0, 1, STATUS_NONE,    128},
      '{DO_EDGE,   3,   4, 0, 0, 0},
      '{DO_EDGE,   3,   4, 0, 0, 0},
      '{DO_RUN,    0,   0, 0, 0, 0},
      '{DO_CFG,    0,   0, 0, 0, 0},
      '{DO_EDGE,   1,   1, 0, 0, 0},
      '{DO_RUN,    0,   0, 1, STATUS_NO_ROOT, 0},
      '{DO_CFG,  127,   0, 0, 0, 0},
      '{DO_EDGE,  64,   2, 0, 0, 0},
      '{DO_EDGE, 100,   1, 0, 0, 0},
      '{DO_RUN,    0,   0, 0, 0, 0},
      '{DO_CFG,    1,   0, 0, 0, 0},
      '{DO_RUN,    0,   0, 1, STATUS_NONE,    2},
      '{DO_CFG,   64,   0, 0, 0, 0},
      '{DO_EDGE,   1,   2, 0, 0, 0},
      '{DO_EDGE,   2,   1, 0, 0, 0},
      '{DO_EDGE,   5,   3, 0, 0, 0},
      '{DO_CFG,    3,   0, 0, 0, 0},
      '{DO_RUN,    0,   0, 0, 0, 0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      case (dir_rows[r].op)
        DO_CFG: begin
          settle();
          write_vcount(dir_rows[r].src);
        end
        DO_EDGE: begin
          push_edge(dir_rows[r].src, dir_rows[r].dst);
        end
        default: begin
          given.status     = StatusW'(dir_rows[r].status);
          given.final_time = TimeW'(dir_rows[r].ftime);
          push_run(dir_rows[r].fixed, given);
        end
      endcase
    end

    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases / 3) begin
        src_idle_pct  = 59;
        sink_idle_pct = 27;
      end else if (p == 2 * NumPhases / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      settle();
      write_vcount(phase_count[p]);
      start = items_sent;
      while (items_sent - start < phase_items[p]) build_and_run();
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 4))
          push_edge($urandom_range(1, clamped_count() + 1), $urandom_range(1, clamped_count()));
      end
    end

    settle();
    $display("ran %0d beats (%0d edges) over %0d vertex-count writes",
             items_sent, edges_sent, cfg_writes);
    $display("searches: %0d acyclic, %0d with a cycle, %0d without a root, %0d mismatches",
             status_seen[STATUS_NONE], status_seen[STATUS_CYCLE],
             status_seen[STATUS_NO_ROOT], mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
